// File: src/ptww_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the glyph width table for the word wrapper.
// No dependencies.
package ptww_pkg;

    localparam int WORD_MAX_DEF  = 32;
    localparam int SEP_UNITS_DEF = 4;

    localparam logic [7:0]  CH_LF = 8'd10;
    localparam logic [7:0]  CH_CR = 8'd13;
    localparam logic [7:0]  CH_SP = 8'd32;

    localparam logic [15:0] MAXW_RST  = 16'd200;
    localparam logic [16:0] CAP_RST   = 17'd1024;
    localparam logic [16:0] CAP_TOP   = 17'd65536;
    localparam logic [8:0]  WW_SAT    = 9'd511;
    localparam logic [16:0] LW_SAT    = 17'h1FFFF;
    localparam logic [15:0] LINES_SAT = 16'hFFFF;

    typedef enum logic {
        REG_MAX_LINE_WIDTH  = 1'b0,
        REG_OUTPUT_CAPACITY = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEL_NL    = 2'd0,
        SEL_SP    = 2'd1,
        SEL_WORD  = 2'd2,
        SEL_FINAL = 2'd3
    } t_gen_sel;

    typedef struct packed {
        logic     load;
        logic     set_open;
        logic     gen;
        t_gen_sel sel;
        logic     count_line;
        logic     close_open;
        logic     word_adv;
        logic     word_done;
        logic     clear;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic in_plain;
        logic is_crlf;
        logic is_space;
        logic is_final;
        logic line_open;
        logic wl_zero;
        logic lw_zero;
        logic wrap;
        logic idx_last;
        logic can_gen;
    } t_sts;

    localparam logic [3:0] GLYPH_W [128] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd4, 4'd2, 4'd4, 4'd7, 4'd6, 4'd9, 4'd7, 4'd2,
        4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd5, 4'd2, 4'd7,
        4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd2, 4'd3, 4'd5, 4'd6, 4'd5, 4'd7,
        4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd8, 4'd8, 4'd6,
        4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd10,
        4'd8, 4'd6, 4'd6, 4'd3, 4'd6, 4'd3, 4'd6, 4'd6,
        4'd4, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6,
        4'd6, 4'd2, 4'd5, 4'd5, 4'd2, 4'd9, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd4, 4'd2, 4'd5, 4'd7, 4'd0
    };

    function automatic logic [3:0] glyph_width(input logic [7:0] c);
        logic [3:0] w;
        w = c[7] ? 4'd0 : GLYPH_W[c[6:0]];
        return w;
    endfunction

endpackage

// File: src/ptww_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the word wrapper: text input, wrapped output, config writes.
// No dependencies.
interface ptww_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       text_end;
    logic       empty_text;
    modport source (output valid, output text_char, output text_end, output empty_text,
                    input ready);
    modport sink (input valid, input text_char, input text_end, input empty_text,
                  output ready);
endinterface

interface ptww_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        run_last;
    logic        text_done;
    logic [15:0] line_count;
    logic        truncated;
    modport source (output valid, output out_char, output char_valid, output run_last,
                    output text_done, output line_count, output truncated, input ready);
    modport sink (input valid, input out_char, input char_valid, input run_last,
                  input text_done, input line_count, input truncated, output ready);
endinterface

interface ptww_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [16:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/ptww_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the word wrapper: steps through flush, word replay, line close and end of text.
// Depends on ptww_pkg.
module ptww_ctrl
    import ptww_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHK   = 9'b000000010,
        S_CLOSE = 9'b000000100,
        S_FLUSH = 9'b000001000,
        S_WORD  = 9'b000010000,
        S_CLNL  = 9'b000100000,
        S_TAIL  = 9'b001000000,
        S_FINAL = 9'b010000000,
        S_END   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_closing, n_closing;
    logic   r_final, n_final;

    always_comb begin
        n_state   = r_state;
        n_closing = r_closing;
        n_final   = r_final;
        o_cmd     = '0;
        o_cmd.sel = SEL_NL;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.in_plain) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_final = 1'b0;
                if (i_sts.is_crlf) begin
                    n_state = S_CLOSE;
                end else if (i_sts.is_space) begin
                    o_cmd.set_open = 1'b1;
                    n_closing      = 1'b0;
                    n_state        = S_FLUSH;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_CLOSE: begin
                if (!i_sts.line_open) begin
                    n_state = r_final ? S_FINAL : S_TAIL;
                end else begin
                    n_closing = 1'b1;
                    n_state   = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.wl_zero) begin
                    n_state = r_closing ? S_CLNL : S_TAIL;
                end else if (i_sts.lw_zero) begin
                    n_state = S_WORD;
                end else if (i_sts.can_gen) begin
                    o_cmd.gen        = 1'b1;
                    o_cmd.sel        = i_sts.wrap ? SEL_NL : SEL_SP;
                    o_cmd.count_line = i_sts.wrap;
                    n_state          = S_WORD;
                end
            end
            S_WORD: begin
                if (i_sts.can_gen) begin
                    o_cmd.gen      = 1'b1;
                    o_cmd.sel      = SEL_WORD;
                    o_cmd.word_adv = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.word_done = 1'b1;
                        n_state = r_closing ? S_CLNL : S_TAIL;
                    end
                end
            end
            S_CLNL: begin
                if (i_sts.can_gen) begin
                    o_cmd.gen        = 1'b1;
                    o_cmd.sel        = SEL_NL;
                    o_cmd.count_line = 1'b1;
                    o_cmd.close_open = 1'b1;
                    n_closing        = 1'b0;
                    n_state          = r_final ? S_FINAL : S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_sts.is_final) begin
                    n_final = 1'b1;
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_END;
                end
            end
            S_FINAL: begin
                if (i_sts.can_gen) begin
                    o_cmd.gen   = 1'b1;
                    o_cmd.sel   = SEL_FINAL;
                    o_cmd.clear = 1'b1;
                    n_final     = 1'b0;
                    n_state     = S_END;
                end
            end
            S_END: begin
                if (i_sts.can_gen) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_closing <= 1'b0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_closing <= n_closing;
            r_final   <= n_final;
        end
    end

endmodule

// File: src/ptww_datapath.sv
`timescale 1ns / 1ps
// Datapath of the word wrapper: word buffer, widths, counters, config registers,
// result staging and output register. Depends on ptww_pkg.
module ptww_datapath
    import ptww_pkg::*;
#(
    parameter int WORD_MAX  = WORD_MAX_DEF,
    parameter int SEP_UNITS = SEP_UNITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_text_char,
    input  logic        i_text_end,
    input  logic        i_empty_text,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [7:0]  o_out_char,
    output logic        o_char_valid,
    output logic        o_run_last,
    output logic        o_text_done,
    output logic [15:0] o_line_count,
    output logic        o_truncated
);

    localparam int WL_W  = $clog2(WORD_MAX + 1);
    localparam int IDX_W = $clog2(WORD_MAX);
    localparam logic [WL_W-1:0] WL_MAX = WL_W'(WORD_MAX);
    localparam logic [17:0]     SPW    = 18'(SEP_UNITS);

    logic [15:0]      r_maxw;
    logic [16:0]      r_cap;
    logic [7:0]       r_ch;
    logic             r_last, r_empty;
    logic [7:0]       r_mem [WORD_MAX];
    logic [7:0]       r_rd;
    logic [WL_W-1:0]  r_wl;
    logic [8:0]       r_ww;
    logic [16:0]      r_lw;
    logic [15:0]      r_lines, n_lines;
    logic [15:0]      r_olen;
    logic             r_open, r_ovf;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic        r_pv;
    logic [7:0]  r_p_ch;
    logic        r_p_val, r_p_done, r_p_trunc;
    logic [15:0] r_p_lines;

    logic        r_ov;
    logic [7:0]  r_o_ch;
    logic        r_o_val, r_o_last, r_o_done, r_o_trunc;
    logic [15:0] r_o_lines;

    logic        in_crlf, in_sp, in_word;
    logic        c_crlf, c_sp;
    logic [15:0] limit;
    logic        emit_ok, is_char, push, out_free, mv, idx_last;
    logic [7:0]  gen_ch;
    logic [17:0] lw_ww, lw_next;
    logic [9:0]  ww_sum;

    assign in_crlf = (i_text_char == CH_CR) || (i_text_char == CH_LF);
    assign in_sp   = (i_text_char == CH_SP);
    assign in_word = !i_empty_text && !in_crlf && !in_sp;
    assign c_crlf  = (r_ch == CH_CR) || (r_ch == CH_LF);
    assign c_sp    = (r_ch == CH_SP);

    always_comb begin
        if (r_cap == 17'd0) begin
            limit = 16'd0;
        end else if (r_cap > CAP_TOP) begin
            limit = LINES_SAT;
        end else begin
            limit = 16'(r_cap - 17'd1);
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_NL:   gen_ch = CH_LF;
            SEL_SP:   gen_ch = CH_SP;
            SEL_WORD: gen_ch = r_rd;
            default:  gen_ch = 8'd0;
        endcase
    end

    assign emit_ok  = r_olen < limit;
    assign is_char  = (i_cmd.sel != SEL_FINAL);
    assign push     = i_cmd.gen && (!is_char || emit_ok);
    assign out_free = !r_ov || i_out_ready;
    assign mv       = out_free && r_pv && (push || i_cmd.finish);
    assign n_lines  = (i_cmd.count_line && r_lines != LINES_SAT) ? r_lines + 16'd1 : r_lines;
    assign lw_ww    = {1'b0, r_lw} + 18'(r_ww);
    assign lw_next  = lw_ww + SPW;
    assign ww_sum   = {1'b0, r_ww} + 10'(glyph_width(i_text_char));
    assign idx_last = (WL_W'(r_idx) + WL_W'(1)) == r_wl;

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.word_adv) begin
            n_idx = idx_last ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        o_sts.in_plain  = in_word && !i_text_end;
        o_sts.is_crlf   = !r_empty && c_crlf;
        o_sts.is_space  = !r_empty && c_sp;
        o_sts.is_final  = r_last || r_empty;
        o_sts.line_open = r_open;
        o_sts.wl_zero   = (r_wl == '0);
        o_sts.lw_zero   = (r_lw == 17'd0);
        o_sts.wrap      = lw_ww > {2'b00, r_maxw};
        o_sts.idx_last  = idx_last;
        o_sts.can_gen   = !r_pv || out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxw  <= MAXW_RST;
            r_cap   <= CAP_RST;
            r_wl    <= '0;
            r_ww    <= 9'd0;
            r_lw    <= 17'd0;
            r_lines <= 16'd0;
            r_olen  <= 16'd0;
            r_open  <= 1'b0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MAX_LINE_WIDTH:  r_maxw <= i_cfg_data[15:0];
                    REG_OUTPUT_CAPACITY: r_cap  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_idx <= n_idx;
            if (i_cmd.load && in_word) begin
                r_open <= 1'b1;
                if (r_wl < WL_MAX) begin
                    r_wl <= r_wl + WL_W'(1);
                    r_ww <= (ww_sum > {1'b0, WW_SAT}) ? WW_SAT : ww_sum[8:0];
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.set_open) begin
                r_open <= 1'b1;
            end
            if (i_cmd.gen && is_char) begin
                if (emit_ok) begin
                    r_olen <= r_olen + 16'd1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.count_line) begin
                r_lines <= n_lines;
                r_lw    <= 17'd0;
            end
            if (i_cmd.close_open) begin
                r_open <= 1'b0;
            end
            if (i_cmd.word_done) begin
                r_lw <= (lw_next > {1'b0, LW_SAT}) ? LW_SAT : lw_next[16:0];
                r_wl <= '0;
                r_ww <= 9'd0;
            end
            if (i_cmd.clear) begin
                r_wl    <= '0;
                r_ww    <= 9'd0;
                r_lw    <= 17'd0;
                r_lines <= 16'd0;
                r_olen  <= 16'd0;
                r_open  <= 1'b0;
                r_ovf   <= 1'b0;
            end
            if (push) begin
                r_pv <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pv <= 1'b0;
            end
            if (out_free) begin
                r_ov <= mv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch    <= i_text_char;
            r_last  <= i_text_end;
            r_empty <= i_empty_text;
        end
        if (i_cmd.load && in_word && r_wl < WL_MAX) begin
            r_mem[r_wl[IDX_W-1:0]] <= i_text_char;
        end
        r_rd <= r_mem[n_idx];
        if (push) begin
            r_p_ch    <= gen_ch;
            r_p_val   <= is_char;
            r_p_done  <= !is_char;
            r_p_lines <= n_lines;
            r_p_trunc <= r_ovf;
        end
        if (mv) begin
            r_o_ch    <= r_p_ch;
            r_o_val   <= r_p_val;
            r_o_done  <= r_p_done;
            r_o_lines <= r_p_lines;
            r_o_trunc <= r_p_trunc;
            r_o_last  <= i_cmd.finish;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_char   = r_o_ch;
    assign o_char_valid = r_o_val;
    assign o_run_last   = r_o_last;
    assign o_text_done  = r_o_done;
    assign o_line_count = r_o_lines;
    assign o_truncated  = r_o_trunc;

endmodule

// File: src/proportional_text_word_wrap.sv
`timescale 1ns / 1ps
// Greedy word wrapper for proportional text: top level joining sequencer and datapath.
// Depends on ptww_pkg, ptww_ifs, ptww_ctrl, ptww_datapath.
//
// A plain word character is accepted while the sequencer is idle and stored in the word
// buffer, without starting a sequence. A space, CR or LF, the empty flag or the end of the
// text holds off the input while a sequence runs: it decodes the item, closes the line,
// flushes the word and ends the text as needed, generating every character in turn
// (separator, each buffered character from the word buffer's single read port, the closing
// newline; a character dropped for capacity takes its step too) and then the final result.
// A stalled output holds the sequence. Results pass a staging register into an output
// register, so each result carries run_last correctly and a full output register only holds
// the sequence while it waits. The word buffer needs no clearing after reset.
module proportional_text_word_wrap
    import ptww_pkg::*;
#(
    parameter int WORD_MAX  = WORD_MAX_DEF,
    parameter int SEP_UNITS = SEP_UNITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    ptww_in_if.sink    i_in,
    ptww_out_if.source o_out,
    ptww_cfg_if.sink   i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    ptww_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ptww_datapath #(
        .WORD_MAX  (WORD_MAX),
        .SEP_UNITS (SEP_UNITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_text_char  (i_in.text_char),
        .i_text_end   (i_in.text_end),
        .i_empty_text (i_in.empty_text),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_char   (o_out.out_char),
        .o_char_valid (o_out.char_valid),
        .o_run_last   (o_out.run_last),
        .o_text_done  (o_out.text_done),
        .o_line_count (o_out.line_count),
        .o_truncated  (o_out.truncated)
    );

endmodule

// File: bench/proportional_text_word_wrap_test.sv
`timescale 1ns / 1ps
// Self-checking bench for proportional_text_word_wrap: directed and random texts are checked
// against an in-bench greedy wrap predictor, with random stalls on input and output.
// Depends on ptww_pkg, ptww_ifs and the wrapper RTL.
module proportional_text_word_wrap_test;
    import ptww_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 64;
    localparam int BUF_DEPTH     = WORD_MAX_DEF;
    localparam int SEP_WIDTH     = SEP_UNITS_DEF;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        char_valid;
        logic        run_last;
        logic        text_done;
        logic [15:0] line_count;
        logic        truncated;
    } t_wrap_out;

    class t_wrap_tracker;
        logic [15:0] line_limit;
        logic [16:0] capacity;
        logic [7:0]  word_buf [BUF_DEPTH];
        int          word_len;
        int          word_w;
        int          line_w;
        int          out_len;
        logic [15:0] lines;
        bit          line_open;
        bit          ovf;
        t_wrap_out   step_q [$];
        t_wrap_out   pending_chars [$];
        int          errors;

        function new();
            line_limit = MAXW_RST;
            capacity   = CAP_RST;
            errors     = 0;
            clear_text();
        endfunction

        function void clear_text();
            word_len  = 0;
            word_w    = 0;
            line_w    = 0;
            out_len   = 0;
            lines     = '0;
            line_open = 1'b0;
            ovf       = 1'b0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [16:0] d);
            case (idx)
                REG_MAX_LINE_WIDTH:  line_limit = d[15:0];
                REG_OUTPUT_CAPACITY: capacity = d;
                default: ;
            endcase
        endfunction

        function void push(logic [7:0] c, logic v, logic d);
            t_wrap_out r;
            r.out_char   = c;
            r.char_valid = v;
            r.run_last   = 1'b0;
            r.text_done  = d;
            r.line_count = lines;
            r.truncated  = ovf;
            step_q.push_back(r);
        endfunction

        function void emit(logic [7:0] c);
            int limit;
            limit = (capacity == 0) ? 0 : int'(capacity) - 1;
            if (limit > 65535) limit = 65535;
            if (out_len < limit) begin
                out_len++;
                push(c, 1'b1, 1'b0);
            end else begin
                ovf = 1'b1;
            end
        endfunction

        function void bump_lines();
            if (lines != LINES_SAT) lines++;
        endfunction

        function void flush_word();
            int i;
            if (word_len == 0) return;
            if (line_w != 0) begin
                if (line_w + word_w > int'(line_limit)) begin
                    line_w = 0;
                    bump_lines();
                    emit(CH_LF);
                end else begin
                    emit(CH_SP);
                end
            end
            for (i = 0; i < word_len; i++) emit(word_buf[i]);
            line_w += word_w + SEP_WIDTH;
            if (line_w > int'(LW_SAT)) line_w = int'(LW_SAT);
            word_len = 0;
            word_w   = 0;
        endfunction

        function void close_line();
            if (!line_open) return;
            flush_word();
            bump_lines();
            emit(CH_LF);
            line_open = 1'b0;
            line_w    = 0;
        endfunction

        function void take_char(logic [7:0] c, logic fin, logic blank);
            t_wrap_out r;
            step_q.delete();
            if (!blank) begin
                if (c == CH_CR || c == CH_LF) begin
                    close_line();
                end else if (c == CH_SP) begin
                    line_open = 1'b1;
                    flush_word();
                end else begin
                    line_open = 1'b1;
                    if (word_len < BUF_DEPTH) begin
                        word_buf[word_len] = c;
                        word_len++;
                        word_w += c[7] ? 0 : int'(GLYPH_W[c[6:0]]);
                        if (word_w > int'(WW_SAT)) word_w = int'(WW_SAT);
                    end else begin
                        ovf = 1'b1;
                    end
                end
            end
            if (blank || fin) begin
                close_line();
                push(8'd0, 1'b0, 1'b1);
                clear_text();
            end
            if (step_q.size() != 0) begin
                r = step_q.pop_back();
                r.run_last = 1'b1;
                step_q.push_back(r);
            end
            foreach (step_q[i]) pending_chars.push_back(step_q[i]);
        endfunction

        function string describe(t_wrap_out r);
            return $sformatf("char %02h valid %b last %b done %b lines %0d trunc %b",
                             r.out_char, r.char_valid, r.run_last, r.text_done,
                             r.line_count, r.truncated);
        endfunction

        function void match_char(t_wrap_out got);
            t_wrap_out want;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual %s",
                         $time, describe(got));
            end else begin
                want = pending_chars.pop_front();
                if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
                    got.run_last !== want.run_last || got.text_done !== want.text_done ||
                    got.line_count !== want.line_count || got.truncated !== want.truncated)
                begin
                    errors++;
                    $display("%0t: mismatch, expected %s, actual %s",
                             $time, describe(want), describe(got));
                end
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    t_wrap_tracker shadow;
    t_wrap_out     got;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            hold_len;
    bit            hold_trig;
    bit            hold_seen;
    int            hold_left;
    int            cycles;
    int            items_sent;

    ptww_in_if  in_if ();
    ptww_out_if out_if ();
    ptww_cfg_if cfg_if ();

    proportional_text_word_wrap dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("proportional_text_word_wrap_test: errors");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen = hold_trig;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.out_char, out_if.char_valid, out_if.run_last,
                    out_if.text_done, out_if.line_count, out_if.truncated};
            shadow.match_char(got);
        end
    end

    task automatic send_item(input logic [7:0] c, input logic fin, input logic blank);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.text_char  = c;
        in_if.text_end   = fin;
        in_if.empty_text = blank;
        do @(posedge i_clk); while (!in_if.ready);
        shadow.take_char(c, fin, blank);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [16:0] d);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = d;
        do @(posedge i_clk); while (!cfg_if.ready);
        shadow.set_reg(idx, d);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic reconfigure(input logic [15:0] width, input logic [16:0] cap);
        in_if.valid = 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(REG_MAX_LINE_WIDTH, {1'b0, width});
        write_reg(REG_OUTPUT_CAPACITY, cap);
    endtask

    // one text of words, space runs, CR/LF runs and stray bytes, at most budget items
    task automatic random_text(input int budget);
        logic [7:0] text [$];
        int         n_tok;
        int         roll;
        int         len;
        n_tok = $urandom_range(1, 8);
        repeat (n_tok) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                len = ($urandom_range(99) < 8) ? $urandom_range(30, 40) : $urandom_range(1, 8);
                repeat (len) begin
                    if ($urandom_range(99) < 85) text.push_back(8'($urandom_range(33, 126)));
                    else text.push_back(8'($urandom_range(0, 255)));
                end
                repeat (($urandom_range(99) < 80) ? 1 : 2) text.push_back(CH_SP);
            end else if (roll < 85) begin
                repeat ($urandom_range(1, 3)) text.push_back($urandom_range(1) ? CH_CR : CH_LF);
            end else if (roll < 93) begin
                repeat ($urandom_range(1, 3)) text.push_back(CH_SP);
            end else begin
                repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (text.size() > budget) void'(text.pop_back());
        if (text.size() < budget && $urandom_range(3) == 0) begin
            foreach (text[i]) send_item(text[i], 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(1)), 1'b1);
        end else begin
            foreach (text[i]) send_item(text[i], (i == text.size() - 1), 1'b0);
        end
    endtask

    task automatic run_texts(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) random_text(n - (items_sent - start));
    endtask

    initial begin
        shadow           = new();
        in_if.valid      = 1'b0;
        in_if.text_char  = 8'd0;
        in_if.text_end   = 1'b0;
        in_if.empty_text = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_MAX_LINE_WIDTH;
        cfg_if.data      = '0;
        out_if.ready     = 1'b0;
        tx_idle_pct      = 13;
        rx_idle_pct      = 88;
        hold_len         = 0;
        i_rst_n          = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty text with nothing pending
        send_item(8'hA5, 1'b0, 1'b1);
        // zero, high and control bytes as word characters, space runs, blank lines
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(CH_SP, 1'b0, 1'b0);
        send_item(CH_SP, 1'b0, 1'b0);
        send_item("W", 1'b0, 1'b0);
        send_item(CH_CR, 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b0);
        send_item(CH_SP, 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item("~", 1'b1, 1'b0);
        // empty flag flushes a pending word
        send_item("a", 1'b0, 1'b0);
        send_item("b", 1'b0, 1'b0);
        send_item(CH_CR, 1'b0, 1'b1);
        // text of one line break, and end together with the empty flag
        send_item(CH_CR, 1'b1, 1'b0);
        send_item(CH_SP, 1'b1, 1'b1);

        reconfigure(16'd0, CAP_TOP);
        run_texts(25);
        reconfigure(16'd40, 17'd20);
        run_texts(25);
        reconfigure(16'hFFFF, 17'd1);
        run_texts(25);

        reconfigure(16'd60, 17'h1FFFF);
        tx_idle_pct = 88;
        rx_idle_pct = 13;
        run_texts(40);
        reconfigure(16'd120, 17'd0);
        run_texts(35);

        reconfigure(16'd35, CAP_RST);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len    = 300;
        hold_trig   = ~hold_trig;
        run_texts(45);
        reconfigure(16'($urandom_range(20, 150)), 17'($urandom_range(5, 200)));
        run_texts(30);

        in_if.valid = 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("proportional_text_word_wrap_test: clean");
        end else begin
            $display("proportional_text_word_wrap_test: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/ptww_pkg.sv
src/ptww_ifs.sv
src/ptww_ctrl.sv
src/ptww_datapath.sv
src/proportional_text_word_wrap.sv
bench/proportional_text_word_wrap_test.sv
